// ===== hw/rtl/bmlpq_pkg.sv =====
package bmlpq_pkg;

	localparam int LEVELS  = 4;
	localparam int NODES   = 256;
	localparam int ID_W    = 16;
	localparam int MAX_CAP = 64;
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int NODE_W  = $clog2(NODES);
	localparam int CAP_W   = 7;
	localparam int CNT_W   = $clog2(MAX_CAP + 1);
	localparam int POOL_W  = $clog2(NODES + 1);
	localparam int OP_W    = 3;
	localparam int ST_W    = 3;
	localparam int CIDX_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ   = 3'd0,
		OP_DEQ   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_UPG   = 3'd3,
		OP_CLEAR = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_LVL_FULL  = 3'd2,
		ST_ALL_FULL  = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_NO_DOWN   = 3'd5,
		ST_TGT_FULL  = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_ENQ_POP,
		S_ENQ_WR,
		S_DEQ_RD,
		S_WALK,
		S_WALK_CMP,
		S_UPG_LINK,
		S_RESP
	} fsm_t;

	function automatic logic [CAP_W-1:0] cap_reset(input int i);
		case (i)
			0: cap_reset = CAP_W'(3);
			1: cap_reset = CAP_W'(10);
			2: cap_reset = CAP_W'(15);
			3: cap_reset = CAP_W'(50);
			default: cap_reset = CAP_W'(MAX_CAP);
		endcase
	endfunction

	function automatic logic [CAP_W-1:0] cap_eff(input logic [CAP_W-1:0] c);
		cap_eff = (c > CAP_W'(MAX_CAP)) ? CAP_W'(MAX_CAP) : c;
	endfunction

endpackage

// ===== hw/rtl/bmlpq_ram.sv =====
module bmlpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/bounded_multi_level_priority_queue_unit.sv =====
// Four strict-priority FIFO levels sharing one linked store of item ids.
// A command word is taken at a clock edge where start is high and busy is low;
// busy stays high until its result has been shown. The result (status, out_id,
// out_level, all_empty) is marked by done, which is high for exactly one cycle.
// The receiver cannot hold a result off, so there is no stall on that side.
// Clear, unknown commands and refused commands go from S_EXEC straight to
// S_RESP. Enqueue passes through S_ENQ_WR, after S_ENQ_POP when the node comes
// from the recycled pool. Dequeue and peek pass through S_DEQ_RD. Upgrade
// walks the linked lists through the node memories, S_WALK and S_WALK_CMP
// for each visited node and S_WALK once per level, then relinks the node in
// S_WALK_CMP and S_UPG_LINK. Each node memory has a single read port.
// Capacity registers are written through the cfg channel, which is always
// ready; writes are meant to happen while busy is low. After reset all levels
// are empty, every node is free and the capacities are 3, 10, 15 and 50.
// No memory clearing pass is needed after reset.
module bounded_multi_level_priority_queue_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [bmlpq_pkg::OP_W-1:0]            opcode,
	input  logic [bmlpq_pkg::ID_W-1:0]            item_id,
	input  logic [bmlpq_pkg::LVL_W-1:0]           level,
	input  logic                                  spill_ok,
	output logic                                  done,
	output logic [bmlpq_pkg::ST_W-1:0]            status,
	output logic [bmlpq_pkg::ID_W-1:0]            out_id,
	output logic [bmlpq_pkg::LVL_W-1:0]           out_level,
	output logic                                  all_empty,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bmlpq_pkg::CIDX_W-1:0]          cfg_index,
	input  logic [bmlpq_pkg::CAP_W-1:0]           cfg_data
);
	import bmlpq_pkg::*;

	fsm_t                 state_q, state_d;
	logic [OP_W-1:0]      op_q;
	logic [ID_W-1:0]      id_q;
	logic [LVL_W-1:0]     lv_q;
	logic                 spill_q;

	logic [CAP_W-1:0]     cap_q   [LEVELS];
	logic [CNT_W-1:0]     cnt_q   [LEVELS], cnt_d [LEVELS];
	logic [NODE_W-1:0]    head_q  [LEVELS], head_d [LEVELS];
	logic [NODE_W-1:0]    tail_q  [LEVELS], tail_d [LEVELS];

	logic [POOL_W-1:0]    fresh_q, fresh_d;
	logic [POOL_W-1:0]    fl_cnt_q, fl_cnt_d;
	logic [NODE_W-1:0]    fl_head_q, fl_head_d;

	logic [NODE_W-1:0]    node_q, node_d;
	logic [LVL_W-1:0]     tl_q, tl_d;
	logic [LVL_W:0]       wl_q, wl_d;
	logic [CNT_W-1:0]     wk_q, wk_d;
	logic [NODE_W-1:0]    prev_q, prev_d;

	logic [ST_W-1:0]      st_q, st_d;
	logic [ID_W-1:0]      oid_q, oid_d;
	logic [LVL_W-1:0]     olv_q, olv_d;

	logic                 id_we;
	logic [NODE_W-1:0]    id_waddr, id_raddr;
	logic [ID_W-1:0]      id_rdata;
	logic                 nx_we;
	logic [NODE_W-1:0]    nx_waddr, nx_wdata, nx_raddr, nx_rdata;

	logic                 en_ok, en_fin;
	logic [LVL_W-1:0]     en_l, en_lvl;
	logic [ST_W-1:0]      en_st;
	logic                 any_busy;
	logic [LVL_W-1:0]     busy_lvl;
	logic                 exhausted;
	logic [LVL_W-1:0]     wl;

	bmlpq_ram #(.WIDTH(ID_W), .DEPTH(NODES)) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (id_waddr),
		.wdata (id_q),
		.raddr (id_raddr),
		.rdata (id_rdata)
	);

	bmlpq_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (nx_raddr),
		.rdata (nx_rdata)
	);

	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_RESP);
	assign status    = st_q;
	assign out_id    = oid_q;
	assign out_level = olv_q;
	assign cfg_ready = 1'b1;
	assign exhausted = (fresh_q == POOL_W'(NODES)) && (fl_cnt_q == '0);
	assign wl        = wl_q[LVL_W-1:0];

	always_comb begin
		all_empty = 1'b1;
		for (int i = 0; i < LEVELS; i++) begin
			if (cnt_q[i] != '0) begin
				all_empty = 1'b0;
			end
		end
	end

	always_comb begin
		any_busy = 1'b0;
		busy_lvl = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				any_busy = 1'b1;
				busy_lvl = LVL_W'(i);
			end
		end
	end

	always_comb begin
		en_ok  = 1'b0;
		en_fin = 1'b0;
		en_st  = ST_OK;
		en_l   = lv_q;
		en_lvl = lv_q;
		for (int i = 0; i < LEVELS; i++) begin
			if (!en_fin) begin
				if (cnt_q[en_l] == '0 ||
				    CAP_W'(cnt_q[en_l]) < cap_eff(cap_q[en_l])) begin
					en_ok  = 1'b1;
					en_lvl = en_l;
					en_fin = 1'b1;
				end else if (en_l == LVL_W'(LEVELS - 1)) begin
					en_st  = ST_ALL_FULL;
					en_fin = 1'b1;
				end else if (!spill_q) begin
					en_st  = ST_LVL_FULL;
					en_fin = 1'b1;
				end else begin
					en_l = en_l + 1'b1;
				end
			end
		end
		if (en_ok && exhausted) begin
			en_ok = 1'b0;
			en_st = ST_ALL_FULL;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		head_d    = head_q;
		tail_d    = tail_q;
		fresh_d   = fresh_q;
		fl_cnt_d  = fl_cnt_q;
		fl_head_d = fl_head_q;
		node_d    = node_q;
		tl_d      = tl_q;
		wl_d      = wl_q;
		wk_d      = wk_q;
		prev_d    = prev_q;
		st_d      = st_q;
		oid_d     = oid_q;
		olv_d     = olv_q;
		id_we     = 1'b0;
		id_waddr  = node_q;
		id_raddr  = node_q;
		nx_we     = 1'b0;
		nx_waddr  = node_q;
		nx_wdata  = node_q;
		nx_raddr  = node_q;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				st_d    = ST_OK;
				oid_d   = '0;
				olv_d   = '0;
				state_d = S_RESP;
				case (op_q)
					OP_ENQ: begin
						if (!en_ok) begin
							st_d = en_st;
						end else begin
							tl_d = en_lvl;
							if (fresh_q != POOL_W'(NODES)) begin
								node_d  = fresh_q[NODE_W-1:0];
								fresh_d = fresh_q + 1'b1;
								state_d = S_ENQ_WR;
							end else begin
								node_d   = fl_head_q;
								nx_raddr = fl_head_q;
								fl_cnt_d = fl_cnt_q - 1'b1;
								state_d  = S_ENQ_POP;
							end
						end
					end
					OP_DEQ, OP_PEEK: begin
						if (!any_busy) begin
							st_d = ST_EMPTY;
						end else begin
							tl_d     = busy_lvl;
							node_d   = head_q[busy_lvl];
							id_raddr = head_q[busy_lvl];
							nx_raddr = head_q[busy_lvl];
							state_d  = S_DEQ_RD;
						end
					end
					OP_UPG: begin
						if (all_empty) begin
							st_d = ST_EMPTY;
						end else begin
							wl_d    = '0;
							wk_d    = '0;
							node_d  = head_q[0];
							prev_d  = '0;
							state_d = S_WALK;
						end
					end
					OP_CLEAR: begin
						for (int i = 0; i < LEVELS; i++) begin
							cnt_d[i]  = '0;
							head_d[i] = '0;
							tail_d[i] = '0;
						end
						fresh_d  = '0;
						fl_cnt_d = '0;
					end
					default: begin
						st_d = ST_OK;
					end
				endcase
			end
			S_ENQ_POP: begin
				fl_head_d = nx_rdata;
				state_d   = S_ENQ_WR;
			end
			S_ENQ_WR: begin
				id_we    = 1'b1;
				id_waddr = node_q;
				if (cnt_q[tl_q] == '0) begin
					head_d[tl_q] = node_q;
				end else begin
					nx_we    = 1'b1;
					nx_waddr = tail_q[tl_q];
					nx_wdata = node_q;
				end
				tail_d[tl_q] = node_q;
				cnt_d[tl_q]  = cnt_q[tl_q] + 1'b1;
				olv_d        = tl_q;
				state_d      = S_RESP;
			end
			S_DEQ_RD: begin
				oid_d = id_rdata;
				olv_d = tl_q;
				if (op_q == OP_DEQ) begin
					head_d[tl_q] = nx_rdata;
					cnt_d[tl_q]  = cnt_q[tl_q] - 1'b1;
					if (cnt_q[tl_q] == CNT_W'(1)) begin
						head_d[tl_q] = '0;
						tail_d[tl_q] = '0;
					end
					nx_we     = 1'b1;
					nx_waddr  = node_q;
					nx_wdata  = fl_head_q;
					fl_head_d = node_q;
					fl_cnt_d  = fl_cnt_q + 1'b1;
				end
				state_d = S_RESP;
			end
			S_WALK: begin
				if (wl_q == (LVL_W + 1)'(LEVELS)) begin
					st_d    = ST_NOT_FOUND;
					state_d = S_RESP;
				end else if (wk_q >= cnt_q[wl]) begin
					wl_d   = wl_q + 1'b1;
					wk_d   = '0;
					prev_d = '0;
					if (wl_q != (LVL_W + 1)'(LEVELS - 1)) begin
						node_d = head_q[wl + 1'b1];
					end
				end else begin
					id_raddr = node_q;
					nx_raddr = node_q;
					state_d  = S_WALK_CMP;
				end
			end
			S_WALK_CMP: begin
				if (id_rdata != id_q) begin
					prev_d  = node_q;
					node_d  = nx_rdata;
					wk_d    = wk_q + 1'b1;
					state_d = S_WALK;
				end else if (wl <= lv_q) begin
					st_d    = ST_NO_DOWN;
					state_d = S_RESP;
				end else if (CAP_W'(cnt_q[lv_q]) >= cap_eff(cap_q[lv_q])) begin
					st_d    = ST_TGT_FULL;
					state_d = S_RESP;
				end else begin
					if (wk_q == '0) begin
						head_d[wl] = nx_rdata;
					end else begin
						nx_we    = 1'b1;
						nx_waddr = prev_q;
						nx_wdata = nx_rdata;
					end
					if (wk_q == cnt_q[wl] - 1'b1) begin
						tail_d[wl] = prev_q;
					end
					cnt_d[wl] = cnt_q[wl] - 1'b1;
					if (cnt_q[wl] == CNT_W'(1)) begin
						head_d[wl] = '0;
						tail_d[wl] = '0;
					end
					state_d = S_UPG_LINK;
				end
			end
			S_UPG_LINK: begin
				if (cnt_q[lv_q] == '0) begin
					head_d[lv_q] = node_q;
				end else begin
					nx_we    = 1'b1;
					nx_waddr = tail_q[lv_q];
					nx_wdata = node_q;
				end
				tail_d[lv_q] = node_q;
				cnt_d[lv_q]  = cnt_q[lv_q] + 1'b1;
				st_d         = ST_OK;
				state_d      = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fresh_q  <= '0;
			fl_cnt_q <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				cap_q[i]  <= cap_reset(i);
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			state_q  <= state_d;
			fresh_q  <= fresh_d;
			fl_cnt_q <= fl_cnt_d;
			cnt_q    <= cnt_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			if (cfg_valid && cfg_index < CIDX_W'(LEVELS)) begin
				cap_q[cfg_index[LVL_W-1:0]] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q    <= opcode;
			id_q    <= item_id;
			lv_q    <= level;
			spill_q <= spill_ok;
		end
		fl_head_q <= fl_head_d;
		node_q    <= node_d;
		tl_q      <= tl_d;
		wl_q      <= wl_d;
		wk_q      <= wk_d;
		prev_q    <= prev_d;
		st_q      <= st_d;
		oid_q     <= oid_d;
		olv_q     <= olv_d;
	end

endmodule
